FILE: sv/eft_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and trig tables of the ellipse fan tessellator.
package eft_pkg;

  localparam int TableEntries = 64;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int SegW         = 6;
  localparam int CntW         = (IdxW + 1 > SegW) ? IdxW + 1 : SegW;
  localparam int DenW         = SegW + 1;
  localparam int NumMax       = 2 * (TableEntries - 1) * (TableEntries - 1) + (TableEntries - 1);
  localparam int NumW         = $clog2(NumMax + 1);
  localparam int DivCntW      = $clog2(NumW);
  localparam int TurnW        = 17 + $clog2(2 * (TableEntries - 1)) + 1;
  localparam int AddrW        = 3;
  localparam int DataW        = 32;
  localparam int ProdW        = 48;

  localparam logic RegMinSegments = 1'b0;
  localparam logic [SegW-1:0] MinSegmentsReset = SegW'(4);

  localparam longint unsigned Q30One    = 64'd1 << 30;
  localparam longint unsigned PiHalfQ30 = 64'd1686629713;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius_x;
    logic [30:0]        radius_y;
    logic [16:0]        start_turn;
    logic [16:0]        end_turn;
    logic [5:0]         segment_count;
    logic [31:0]        rgba;
  } req_t;

  typedef struct packed {
    logic signed [31:0] hub_x;
    logic signed [31:0] hub_y;
    logic signed [31:0] vertex_z;
    logic signed [31:0] new_rim_x;
    logic signed [31:0] new_rim_y;
    logic signed [31:0] old_rim_x;
    logic signed [31:0] old_rim_y;
    logic [31:0]        tri_color;
    logic               last_triangle;
  } tri_t;

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StMulX,
    StMulY,
    StAddY,
    StEmit,
    StDivGo,
    StDivWait
  } eft_state_e;

  typedef logic signed [15:0] trig_tbl_t [TableEntries];

  function automatic logic signed [15:0] to_q15(longint unsigned v);
    longint unsigned r;
    r = (v + 64'd16384) >> 15;
    return (r > 64'd32767) ? 16'sd32767 : 16'(r);
  endfunction

  // sel = 0 builds cosine, sel = 1 builds sine; Q2.30 Taylor series per entry
  function automatic trig_tbl_t build_table(bit sel);
    trig_tbl_t         tbl;
    longint unsigned   p, quad, rem, x, x2, t, term, s, c;
    logic signed [15:0] cs, sn;
    for (int i = 0; i < TableEntries; i++) begin
      p    = ((longint'(i) << 32) + TableEntries / 2) / TableEntries;
      quad = (p >> 30) & 64'd3;
      rem  = p & (Q30One - 64'd1);
      x    = (rem * PiHalfQ30 + (64'd1 << 29)) >> 30;
      x2   = (x * x) >> 30;
      t    = Q30One;
      t    = Q30One - ((x2 * t) >> 30) / 156;
      t    = Q30One - ((x2 * t) >> 30) / 110;
      t    = Q30One - ((x2 * t) >> 30) / 72;
      t    = Q30One - ((x2 * t) >> 30) / 42;
      t    = Q30One - ((x2 * t) >> 30) / 20;
      t    = Q30One - ((x2 * t) >> 30) / 6;
      s    = (x * t) >> 30;
      t    = Q30One;
      t    = Q30One - ((x2 * t) >> 30) / 132;
      t    = Q30One - ((x2 * t) >> 30) / 90;
      t    = Q30One - ((x2 * t) >> 30) / 56;
      t    = Q30One - ((x2 * t) >> 30) / 30;
      t    = Q30One - ((x2 * t) >> 30) / 12;
      term = ((x2 * t) >> 30) / 2;
      c    = (term > Q30One) ? 64'd0 : Q30One - term;
      cs   = to_q15(c);
      sn   = to_q15(s);
      unique case (quad[1:0])
        2'd0: tbl[i] = sel ? sn : cs;
        2'd1: tbl[i] = sel ? cs : -sn;
        2'd2: tbl[i] = sel ? -sn : -cs;
        default: tbl[i] = sel ? -cs : sn;
      endcase
    end
    tbl[TableEntries-1] = sel ? 16'sd0 : 16'sd32767;
    return tbl;
  endfunction

  localparam trig_tbl_t CosTable = build_table(1'b0);
  localparam trig_tbl_t SinTable = build_table(1'b1);

endpackage

FILE: sv/eft_if.sv
`timescale 1ns / 1ps
// Request and triangle stream interfaces.
interface eft_req_if;
  logic          valid;
  logic          ready;
  eft_pkg::req_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface eft_tri_if;
  logic          valid;
  logic          ready;
  eft_pkg::tri_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

FILE: sv/eft_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider for the rim table index.
module eft_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [eft_pkg::NumW-1:0]    num_i,
  input  logic [eft_pkg::DenW-1:0]    den_i,
  output logic                        done_o,
  output logic [eft_pkg::NumW-1:0]    quo_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [eft_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [eft_pkg::DenW-1:0]      rem_q, rem_d;
  logic [eft_pkg::NumW-1:0]      quo_q, quo_d;
  logic [eft_pkg::DenW:0]        trial;
  logic                          qbit;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[eft_pkg::NumW-1]};
    qbit   = (trial >= {1'b0, den_i});
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = qbit ? eft_pkg::DenW'(trial - {1'b0, den_i}) : eft_pkg::DenW'(trial);
      quo_d = {quo_q[eft_pkg::NumW-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == eft_pkg::DivCntW'(eft_pkg::NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: sv/ellipse_fan_tessellator_core.sv
`timescale 1ns / 1ps
// Top level: ellipse / pie-slice triangle fan tessellator.
//
//   channel   dir   handshake           word
//   req_i     in    valid/ready         one ellipse or pie request
//   tri_o     out   valid/ready         one fan triangle
//   apb       in    psel/penable/pready min_segments register at 0x0
//
// Request time is set by the 13-step serial divider that forms each
// table index and the shared 16x32 multiplier, used twice per rim point.
// One request at a time.
// Reset clears control only; the sine and cosine tables are constants.
// One triangle waits in the output register; the sequencer stalls in the emit
// step while it is still full.
module ellipse_fan_tessellator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  eft_req_if.sink                    req_i,
  eft_tri_if.source                  tri_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [eft_pkg::AddrW-1:0]  paddr,
  input  logic [eft_pkg::DataW-1:0]  pwdata,
  output logic [eft_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  localparam int IdxW = eft_pkg::IdxW;
  localparam int SegW = eft_pkg::SegW;
  localparam int CntW = eft_pkg::CntW;
  localparam int NumW = eft_pkg::NumW;

  eft_pkg::eft_state_e        state_q, state_d;
  logic [SegW-1:0]            min_seg_q;
  logic [SegW-1:0]            k_q, k_d;
  logic                       out_valid_q, out_valid_d;
  eft_pkg::req_t              req_q, req_d;
  eft_pkg::tri_t              out_q, out_d;
  logic [IdxW-1:0]            first_q, first_d;
  logic [IdxW-1:0]            span_q, span_d;
  logic [SegW-1:0]            segs_q, segs_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic signed [eft_pkg::ProdW-1:0] prod_q, prod_d;
  logic signed [31:0]         new_x_q, new_x_d, new_y_q, new_y_d;
  logic signed [31:0]         old_x_q, old_x_d, old_y_q, old_y_d;
  logic [NumW-1:0]            num_q, num_d;

  logic                       div_start, div_done;
  logic [NumW-1:0]            div_quo;
  logic signed [15:0]         mul_a;
  logic [30:0]                mul_b;
  logic signed [eft_pkg::ProdW-1:0] mul_p;
  logic signed [31:0]         add_base;
  logic signed [31:0]         add_res;
  logic [IdxW-1:0]            ti_first, ti_last;
  logic [CntW-1:0]            seg_pick;
  logic [IdxW:0]              idx_sum;
  logic                       cfg_wr;

  function automatic logic [IdxW-1:0] turn_index(logic [16:0] t);
    logic [16:0]             ts;
    logic [eft_pkg::TurnW-1:0] acc;
    ts  = (t > 17'd65536) ? 17'd65536 : t;
    acc = eft_pkg::TurnW'(ts) * eft_pkg::TurnW'(2 * (eft_pkg::TableEntries - 1))
        + eft_pkg::TurnW'(65536);
    return IdxW'(acc >> 17);
  endfunction

  function automatic logic signed [31:0] scale_add(logic signed [eft_pkg::ProdW-1:0] p,
                                                   logic signed [31:0] base);
    logic signed [eft_pkg::ProdW-1:0] rnd;
    logic [33:0]                      sum;
    rnd = p + eft_pkg::ProdW'(16384);
    sum = {{2{base[31]}}, base} + {rnd[eft_pkg::ProdW-1], rnd[eft_pkg::ProdW-1:15]};
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      return sum[31:0];
    end else if (sum[33]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  // shared multiplier and saturating adder
  assign mul_a    = (state_q == eft_pkg::StMulX) ? eft_pkg::CosTable[idx_q]
                                                 : eft_pkg::SinTable[idx_q];
  assign mul_b    = (state_q == eft_pkg::StMulX) ? req_q.radius_x : req_q.radius_y;
  assign mul_p    = mul_a * $signed({1'b0, mul_b});
  assign add_base = (state_q == eft_pkg::StMulY) ? req_q.center_x : req_q.center_y;
  assign add_res  = scale_add(prod_q, add_base);

  assign ti_first = turn_index(req_q.start_turn);
  assign ti_last  = turn_index(req_q.end_turn);
  assign idx_sum  = {1'b0, first_q} + (IdxW + 1)'(div_quo);

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !tri_o.ready;
    req_d       = req_q;
    out_d       = out_q;
    first_d     = first_q;
    span_d      = span_q;
    segs_d      = segs_q;
    idx_d       = idx_q;
    prod_d      = prod_q;
    new_x_d     = new_x_q;
    new_y_d     = new_y_q;
    old_x_d     = old_x_q;
    old_y_d     = old_y_q;
    num_d       = num_q;
    div_start   = 1'b0;
    seg_pick    = '0;

    unique case (state_q)
      eft_pkg::StIdle: begin
        if (req_i.valid) begin
          req_d   = req_i.payload;
          state_d = eft_pkg::StSetup;
        end
      end
      eft_pkg::StSetup: begin
        if (req_q.req_type) begin
          first_d = ti_first;
          span_d  = ti_last - ti_first;
          seg_pick = (CntW'(req_q.segment_count) < CntW'(span_d))
                   ? CntW'(req_q.segment_count) : CntW'(span_d);
        end else begin
          first_d = '0;
          span_d  = IdxW'(eft_pkg::TableEntries - 1);
          seg_pick = (CntW'(req_q.segment_count) < CntW'(min_seg_q))
                   ? CntW'(min_seg_q) : CntW'(req_q.segment_count);
          if (seg_pick > CntW'(eft_pkg::TableEntries - 1)) begin
            seg_pick = CntW'(eft_pkg::TableEntries - 1);
          end
        end
        segs_d = SegW'(seg_pick);
        idx_d  = first_d;
        k_d    = '0;
        if ((req_q.req_type && ti_last < ti_first) || seg_pick == '0) begin
          state_d = eft_pkg::StIdle;
        end else begin
          state_d = eft_pkg::StMulX;
        end
      end
      eft_pkg::StMulX: begin
        prod_d  = mul_p;
        state_d = eft_pkg::StMulY;
      end
      eft_pkg::StMulY: begin
        new_x_d = add_res;
        prod_d  = mul_p;
        state_d = eft_pkg::StAddY;
      end
      eft_pkg::StAddY: begin
        new_y_d = add_res;
        state_d = eft_pkg::StEmit;
      end
      eft_pkg::StEmit: begin
        if (k_q == '0) begin
          old_x_d = new_x_q;
          old_y_d = new_y_q;
          k_d     = SegW'(1);
          num_d   = NumW'(segs_q) + NumW'({span_q, 1'b0});
          state_d = eft_pkg::StDivGo;
        end else if (!out_valid_q || tri_o.ready) begin
          out_d.hub_x         = req_q.center_x;
          out_d.hub_y         = req_q.center_y;
          out_d.vertex_z      = req_q.center_z;
          out_d.new_rim_x     = new_x_q;
          out_d.new_rim_y     = new_y_q;
          out_d.old_rim_x     = old_x_q;
          out_d.old_rim_y     = old_y_q;
          out_d.tri_color     = req_q.rgba;
          out_d.last_triangle = (k_q == segs_q);
          out_valid_d         = 1'b1;
          old_x_d             = new_x_q;
          old_y_d             = new_y_q;
          if (k_q == segs_q) begin
            state_d = eft_pkg::StIdle;
          end else begin
            k_d     = k_q + 1'b1;
            num_d   = num_q + NumW'({span_q, 1'b0});
            state_d = eft_pkg::StDivGo;
          end
        end
      end
      eft_pkg::StDivGo: begin
        div_start = 1'b1;
        state_d   = eft_pkg::StDivWait;
      end
      eft_pkg::StDivWait: begin
        if (div_done) begin
          idx_d   = (idx_sum >= (IdxW + 1)'(eft_pkg::TableEntries))
                  ? IdxW'(eft_pkg::TableEntries - 1) : IdxW'(idx_sum);
          state_d = eft_pkg::StMulX;
        end
      end
      default: state_d = eft_pkg::StIdle;
    endcase
  end

  eft_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   ({segs_q, 1'b0}),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == eft_pkg::RegMinSegments);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= eft_pkg::StIdle;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      min_seg_q   <= eft_pkg::MinSegmentsReset;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        min_seg_q <= pwdata[SegW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    out_q   <= out_d;
    first_q <= first_d;
    span_q  <= span_d;
    segs_q  <= segs_d;
    idx_q   <= idx_d;
    prod_q  <= prod_d;
    new_x_q <= new_x_d;
    new_y_q <= new_y_d;
    old_x_q <= old_x_d;
    old_y_q <= old_y_d;
    num_q   <= num_d;
  end

  assign req_i.ready   = (state_q == eft_pkg::StIdle);
  assign tri_o.valid   = out_valid_q;
  assign tri_o.payload = out_q;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == eft_pkg::RegMinSegments)
                       ? eft_pkg::DataW'(min_seg_q) : '0;

endmodule

FILE: sv/eft_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the fan tessellator, bound to the top level.
module eft_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input eft_pkg::tri_t out_word_i,
  input logic          psel_i,
  input logic          pready_i
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after an accepted request");

  a_no_early_triangle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> ##1 !$rose(out_valid_i))
    else $error("triangle appeared too soon after a request");

  a_fan_open_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_word_i.last_triangle) |-> !in_ready_i)
    else $error("new request taken while a fan is still open");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_word_i)))
    else $error("stalled triangle word changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i |-> pready_i)
    else $error("config access without pready");

endmodule

bind ellipse_fan_tessellator_core eft_checker u_eft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (tri_o.valid),
  .out_ready_i (tri_o.ready),
  .out_word_i  (tri_o.payload),
  .psel_i      (psel),
  .pready_i    (pready)
);
